// File: src/bchd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types, constants and GF(2^m) helpers of the binary BCH decoder.
// ----------------------------------------------------------------------------
package bchd_pkg;

  localparam int MAX_DEGREE   = 6;
  localparam int MAX_DISTANCE = 17;
  localparam int POLY_LEN     = MAX_DISTANCE + 1;
  localparam int ALPHA_LEN    = 64;
  localparam int EW           = MAX_DEGREE;       // field element width
  localparam int PW           = MAX_DEGREE + 1;   // field polynomial width
  localparam int WORD_W       = 63;
  localparam int LEN_W        = 6;
  localparam int DIST_W       = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DESIGN_DIST = 2'd2;

  typedef struct packed {
    logic [PW-1:0]     poly;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] distance;
  } bchd_cfg_t;

  typedef struct packed {
    logic              zero;   // code length of zero: result is all zeros
    logic [WORD_W-1:0] word;   // received word masked to the code length
  } bchd_item_t;

  // One-hot of the highest set bit of the field polynomial, bit 0 if none above it.
  function automatic logic [PW-1:0] field_top(input logic [PW-1:0] poly);
    logic [PW-1:0] t;
    t = {{(PW-1){1'b0}}, 1'b1};
    for (int i = 1; i < PW; i++) begin
      if (poly[i]) begin
        t    = '0;
        t[i] = 1'b1;
      end
    end
    return t;
  endfunction

  // Multiply the previous power by x and reduce.
  function automatic logic [EW-1:0] gf_step(input logic [EW-1:0] v, input logic [PW-1:0] poly,
                                            input logic [PW-1:0] top);
    logic [PW-1:0] r;
    r = {v, 1'b0};
    if ((r & top) != '0) r = r ^ poly;
    return r[EW-1:0];
  endfunction

  // Shift-and-add product, reduced on the top bit of the field polynomial.
  function automatic logic [EW-1:0] gf_mul(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                           input logic [PW-1:0] poly, input logic [PW-1:0] top);
    logic [PW-1:0] r;
    r = '0;
    for (int i = EW - 1; i >= 0; i--) begin
      r = {r[PW-2:0], 1'b0};
      if ((r & top) != '0) r = r ^ poly;
      if (b[i]) r = r ^ {1'b0, a};
    end
    return r[EW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: src/bchd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bchd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/bchd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_front
// Input side: mask the received word to the code length, flag zero length,
// and hold up to two words for the decode engine.
// ----------------------------------------------------------------------------
module bchd_front
  import bchd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bchd_cfg_t         cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_word,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output bchd_item_t             q_item
);

  bchd_item_t  slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] mask;
  logic        push, pop;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) mask[j] = (LEN_W'(j) < cfg.len);
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r].word <= in_word & mask;
      slot_r[wr_ptr_r].zero <= (cfg.len == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("queue count out of range");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 && !pop) |=> count_r == 2'd2)
    else $error("full queue changed without a pop");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// File: src/bchd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bchd_back
// Decode engine: power table fill, syndromes, Berlekamp-Massey, Chien search,
// and the output register.
// ----------------------------------------------------------------------------
module bchd_back
  import bchd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bchd_cfg_t         cfg,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire bchd_item_t        q_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_word
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILL = 4'd1;
  localparam logic [3:0] S_SYN_A = 4'd2;
  localparam logic [3:0] S_SYN_D = 4'd3;
  localparam logic [3:0] S_BM_D = 4'd4;
  localparam logic [3:0] S_BM_U = 4'd5;
  localparam logic [3:0] S_BM_L = 4'd6;
  localparam logic [3:0] S_BM_I = 4'd7;
  localparam logic [3:0] S_CH_A = 4'd8;
  localparam logic [3:0] S_CH_D = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  localparam int AW = $clog2(ALPHA_LEN);
  localparam logic [DIST_W-1:0] LAST_J = DIST_W'(POLY_LEN - 1);

  logic [3:0]        state_r;
  logic [WORD_W-1:0] word_r;
  logic [LEN_W-1:0]  kk_r;
  logic [DIST_W-1:0] i_r, jj_r, len_r;
  logic [LEN_W-1:0]  e_r, step_r;
  logic [EW-1:0]     a_r, acc_r, delta_r;
  logic [ALPHA_LEN-1:0] seen_r;
  logic [EW-1:0]     syn_r [1:MAX_DISTANCE-1];
  logic [EW-1:0]     loc_r [POLY_LEN];
  logic [EW-1:0]     comp_r [POLY_LEN];
  logic [EW-1:0]     comp_sh [POLY_LEN];
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;

  logic [PW-1:0]     top;
  logic [DIST_W-1:0] dd, dlast, bm_lim;
  logic [LEN_W-1:0]  n, nm1, e_add, inv_idx, flip_idx, step_inc;
  logic [LEN_W:0]    e_sum;
  logic [EW-1:0]     alpha_rd, log_rd, bm_term, ch_acc, syn_acc, inv;
  logic [LEN_W-1:0]  alpha_raddr;
  logic              out_free;

  assign top   = field_top(cfg.poly);
  assign dd    = (cfg.distance > DIST_W'(MAX_DISTANCE)) ? DIST_W'(MAX_DISTANCE) : cfg.distance;
  assign dlast = dd - 1'b1;
  assign n     = cfg.len;
  assign nm1   = n - 1'b1;

  // Next exponent: (e + step) mod n, with both below n.
  assign e_sum = {1'b0, e_r} + {1'b0, step_r};
  assign e_add = (e_sum >= {1'b0, n}) ? LEN_W'(e_sum - {1'b0, n}) : e_sum[LEN_W-1:0];
  assign step_inc = (step_r == nm1) ? '0 : step_r + 1'b1;

  assign bm_lim  = (len_r < i_r - 1'b1) ? len_r : i_r - 1'b1;
  assign bm_term = gf_mul(loc_r[jj_r], syn_r[i_r - jj_r], cfg.poly, top);
  assign inv_idx = (log_rd == '0) ? '0 : n - log_rd;
  assign inv     = seen_r[delta_r] ? alpha_rd : '0;
  assign ch_acc  = acc_r ^ gf_mul(loc_r[jj_r], alpha_rd, cfg.poly, top);
  assign syn_acc = word_r[kk_r] ? (acc_r ^ alpha_rd) : acc_r;
  assign flip_idx = (kk_r == '0) ? '0 : n - kk_r;

  always_comb begin
    comp_sh[0] = '0;
    for (int i = 1; i < POLY_LEN; i++) comp_sh[i] = comp_r[i-1];
  end

  assign alpha_raddr = (state_r == S_BM_L) ? inv_idx : e_r;

  bchd_ram #(.WIDTH(EW), .DEPTH(ALPHA_LEN)) u_alpha (
    .clk   (clk),
    .we    (state_r == S_FILL),
    .waddr (AW'(kk_r)),
    .wdata (a_r),
    .raddr (AW'(alpha_raddr)),
    .rdata (alpha_rd)
  );

  // Log table keeps the first exponent that reaches each value.
  bchd_ram #(.WIDTH(EW), .DEPTH(ALPHA_LEN)) u_log (
    .clk   (clk),
    .we    ((state_r == S_FILL) && !seen_r[a_r]),
    .waddr (AW'(a_r)),
    .wdata (kk_r),
    .raddr (AW'(delta_r)),
    .rdata (log_rd)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            word_r <= q_item.word;
            kk_r   <= '0;
            a_r    <= EW'(1);
            seen_r <= '0;
            len_r  <= '0;
            for (int i = 0; i < POLY_LEN; i++) begin
              loc_r[i]  <= (i == 0) ? EW'(1) : '0;
              comp_r[i] <= (i == 0) ? EW'(1) : '0;
            end
            state_r <= q_item.zero ? S_DONE : S_FILL;
          end
        end
        S_FILL: begin
          seen_r[a_r] <= 1'b1;
          a_r   <= gf_step(a_r, cfg.poly, top);
          e_r   <= '0;
          acc_r <= '0;
          if (kk_r == nm1) begin
            kk_r <= '0;
            if (dd > DIST_W'(1)) begin
              i_r     <= DIST_W'(1);
              step_r  <= (n == LEN_W'(1)) ? '0 : LEN_W'(1);
              state_r <= S_SYN_A;
            end else begin
              jj_r    <= '0;
              step_r  <= '0;
              state_r <= S_CH_A;
            end
          end else begin
            kk_r <= kk_r + 1'b1;
          end
        end
        S_SYN_A: state_r <= S_SYN_D;
        S_SYN_D: begin
          if (kk_r == nm1) begin
            syn_r[i_r] <= syn_acc;
            acc_r <= '0;
            e_r   <= '0;
            kk_r  <= '0;
            if (i_r == dlast) begin
              i_r     <= DIST_W'(1);
              jj_r    <= '0;
              delta_r <= '0;
              state_r <= S_BM_D;
            end else begin
              i_r     <= i_r + 1'b1;
              step_r  <= step_inc;
              state_r <= S_SYN_A;
            end
          end else begin
            acc_r   <= syn_acc;
            e_r     <= e_add;
            kk_r    <= kk_r + 1'b1;
            state_r <= S_SYN_A;
          end
        end
        S_BM_D: begin
          delta_r <= delta_r ^ bm_term;
          if (jj_r == bm_lim) state_r <= S_BM_U;
          else jj_r <= jj_r + 1'b1;
        end
        S_BM_U: begin
          for (int i = 0; i < POLY_LEN; i++) comp_r[i] <= comp_sh[i];
          if (delta_r != '0 && ({len_r, 1'b0} <= {1'b0, i_r - 1'b1})) begin
            state_r <= S_BM_L;
          end else begin
            if (delta_r != '0) begin
              for (int i = 0; i < POLY_LEN; i++)
                loc_r[i] <= gf_mul(comp_sh[i], delta_r, cfg.poly, top) ^ loc_r[i];
            end
            jj_r    <= '0;
            delta_r <= '0;
            if (i_r == dlast) begin
              kk_r <= '0; step_r <= '0; e_r <= '0; acc_r <= '0;
              state_r <= S_CH_A;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_BM_D;
            end
          end
        end
        S_BM_L: state_r <= S_BM_I;
        S_BM_I: begin
          for (int i = 0; i < POLY_LEN; i++) begin
            comp_r[i] <= gf_mul(inv, loc_r[i], cfg.poly, top);
            loc_r[i]  <= gf_mul(comp_r[i], delta_r, cfg.poly, top) ^ loc_r[i];
          end
          len_r   <= i_r - len_r;
          jj_r    <= '0;
          delta_r <= '0;
          if (i_r == dlast) begin
            kk_r <= '0; step_r <= '0; e_r <= '0; acc_r <= '0;
            state_r <= S_CH_A;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_BM_D;
          end
        end
        S_CH_A: state_r <= S_CH_D;
        S_CH_D: begin
          if (jj_r == LAST_J) begin
            if (ch_acc == '0) word_r[flip_idx] <= ~word_r[flip_idx];
            acc_r <= '0;
            e_r   <= '0;
            jj_r  <= '0;
            if (kk_r == nm1) begin
              state_r <= S_DONE;
            end else begin
              kk_r    <= kk_r + 1'b1;
              step_r  <= kk_r + 1'b1;
              state_r <= S_CH_A;
            end
          end else begin
            acc_r   <= ch_acc;
            e_r     <= e_add;
            jj_r    <= jj_r + 1'b1;
            state_r <= S_CH_A;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_word_r  <= word_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CH_D || state_r == S_SYN_D) |-> e_r < n)
    else $error("exponent not reduced below code length");
  a_inv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BM_L || state_r == S_BM_I) |-> delta_r != '0)
    else $error("inverse lookup for a zero discrepancy");
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished word not loaded into output register");

endmodule
`default_nettype wire

// File: src/bch_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bch_decoder
// Binary BCH decoder: syndromes, Berlekamp-Massey and Chien search over
// GF(2^m) set by the configured field polynomial.
// ----------------------------------------------------------------------------
// Per word: the engine fills the power table, computes d'-1 syndromes, runs
// d'-1 Berlekamp-Massey rounds and a Chien search over n positions, where
// d' = min(d,17); a zero length word goes straight to the output register.
// The engine holds one word at a time; the input queue takes two more words meanwhile.
// Reset (rst_n low, synchronous): registers go to field_poly 19, code_length
// 15, design_distance 5; queue and engine empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bch_decoder
  import bchd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [63:0]           in_tdata,   // [62:0] received_word, [63] pad
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [63:0]                out_tdata   // [62:0] corrected_word, [63] zero
);

  bchd_cfg_t         cfg_r;
  logic              q_valid, q_ready;
  bchd_item_t        q_item;
  logic [WORD_W-1:0] out_word;

  // Config is always ready; write only while no word is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly     <= PW'(19);
      cfg_r.len      <= LEN_W'(15);
      cfg_r.distance <= DIST_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIELD_POLY:  cfg_r.poly     <= cfg_data[PW-1:0];
        REG_CODE_LENGTH: cfg_r.len      <= cfg_data[LEN_W-1:0];
        REG_DESIGN_DIST: cfg_r.distance <= cfg_data[DIST_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: mask and queue each transfer.
  bchd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_word  (in_tdata[WORD_W-1:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // Back: decode one word and hold it in the output register.
  bchd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = {1'b0, out_word};

endmodule
`default_nettype wire
